[hdl/sixteen_bit_execution_unit_top_defines.svh]
// ---------------------------------------------------------------------------
// sixteen_bit_execution_unit_top_defines
// assertion macros shared by the execution unit rtl
// ---------------------------------------------------------------------------
`ifndef SIXTEEN_BIT_EXECUTION_UNIT_TOP_DEFINES_SVH
`define SIXTEEN_BIT_EXECUTION_UNIT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every rising edge outside reset
`define SBEU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sbeu assertion failed");
// implication checked in the same cycle
`define SBEU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbeu assertion failed");
// implication whose consequent is checked in the next cycle
`define SBEU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbeu assertion failed");
`else
`define SBEU_ASSERT(label, prop)
`define SBEU_ASSERT_IMP(label, ante, cons)
`define SBEU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/sbeu_pkg.sv]
// ---------------------------------------------------------------------------
// sbeu_pkg
// types and codes of the 16-bit execution unit
// ---------------------------------------------------------------------------
`default_nettype none

package sbeu_pkg;

  typedef enum logic [4:0] {
    OP_ADD      = 5'd0,
    OP_SUB      = 5'd1,
    OP_CMP      = 5'd2,
    OP_AND      = 5'd3,
    OP_OR       = 5'd4,
    OP_XOR      = 5'd5,
    OP_PASS     = 5'd6,
    OP_MUL      = 5'd7,
    OP_LSHIFT   = 5'd8,
    OP_ASHIFT   = 5'd9,
    OP_ROTATE   = 5'd10,
    OP_ROTCARRY = 5'd11,
    OP_MINMAX   = 5'd12,
    OP_NEGNOT   = 5'd13,
    OP_BTEST    = 5'd14,
    OP_BSET     = 5'd15,
    OP_BCLR     = 5'd16,
    OP_DEC      = 5'd17,
    OP_COND     = 5'd18
  } sbeu_op_e;

  typedef enum logic [3:0] {
    CC_NZ     = 4'd0,
    CC_Z      = 4'd1,
    CC_NC     = 4'd2,
    CC_C      = 4'd3,
    CC_NN     = 4'd4,
    CC_N      = 4'd5,
    CC_NV     = 4'd6,
    CC_V      = 4'd7,
    CC_NEVER  = 4'd8,
    CC_HI     = 4'd9,
    CC_LS     = 4'd10,
    CC_GT     = 4'd11,
    CC_GE     = 4'd12,
    CC_LE     = 4'd13,
    CC_LT     = 4'd14,
    CC_ALWAYS = 4'd15
  } sbeu_cc_e;

  localparam int unsigned FlagZ = 0;
  localparam int unsigned FlagN = 1;
  localparam int unsigned FlagC = 2;
  localparam int unsigned FlagV = 3;

  localparam logic [3:0] MaskAll  = 4'b1111;
  localparam logic [3:0] MaskZ    = 4'b0001;
  localparam logic [3:0] MaskZnv  = 4'b1011;
  localparam logic [3:0] MaskNone = 4'b0000;

  localparam logic [31:0] MulHighMask = 32'hffff_0000;
  localparam logic [31:0] MulPosLimit = 32'h0000_8000;
  localparam logic [31:0] MulNegLimit = 32'hffff_8000;

  typedef struct packed {
    logic [4:0]  operation;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
    logic        byte_operand;
    logic        signed_mode;
    logic        right_or_min;
    logic [3:0]  amount;
    logic [3:0]  flags_in;
  } sbeu_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic        write_back;
    logic [3:0]  flags_out;
    logic [3:0]  flags_written;
    logic        condition_true;
  } sbeu_rsp_t;

endpackage

`default_nettype wire

[hdl/sixteen_bit_execution_unit_top.sv]
// ---------------------------------------------------------------------------
// sixteen_bit_execution_unit_top
// alu, multiplier, shifter, bit ops and branch conditions of a 16-bit core
// ---------------------------------------------------------------------------
//  channel   ports                   dir  accepted when
//  request   start_i, busy_o, req_i  in   start_i && !busy_o at a rising edge
//  result    done_o, rsp_o           out  done_o high, taken at the next edge
//
//  one word per cycle; busy_o stays low
//  a request passes the input register, then one pass of logic into the result
//  register; the 16x16 multiplier sets the longest path
//  reset clears the valid and strobe flags only
//  the receiver cannot stall, so no result is ever held back
// ---------------------------------------------------------------------------
`default_nettype none
`include "sixteen_bit_execution_unit_top_defines.svh"

module sixteen_bit_execution_unit_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  wire sbeu_pkg::sbeu_req_t req_i,
  output logic                done_o,
  output sbeu_pkg::sbeu_rsp_t rsp_o
);
  import sbeu_pkg::*;

  logic      in_vld_q;
  sbeu_req_t req_q;
  logic      done_q;
  sbeu_rsp_t rsp_q;
  sbeu_rsp_t rsp_d;
  logic      chk_keep_ok;
  logic      chk_dest_ok;
  logic      chk_cond_ok;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
      done_q   <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
    if (in_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] b_raw;
    logic [3:0]  s;
    logic [3:0]  fin;
    logic        sgn;
    logic        right;
    logic        z;
    logic        n;
    logic        c;
    logic        v;
    logic [16:0] sum;
    logic [15:0] diff;
    logic [31:0] ae;
    logic [31:0] be;
    logic [31:0] prod;
    logic [4:0]  inv_s;
    logic [4:0]  rc_amt;
    logic [31:0] dbl;
    logic [31:0] dbl_l;
    logic [16:0] v17;
    logic [33:0] dv;
    logic [15:0] sh_l;
    logic [15:0] sh_r;
    logic [15:0] sh_a;
    logic [15:0] rot_r;
    logic [15:0] rot_l;
    logic [15:0] rc_r;
    logic [15:0] rc_l;
    logic        c_left;
    logic        c_right;
    logic [15:0] shres;
    logic        a_less;
    logic        bit_set;
    logic [15:0] bit_mask;
    logic [15:0] res;
    logic [3:0]  f;
    logic [3:0]  mask;
    logic        wb;
    logic        cond;

    a     = req_q.first_operand;
    b_raw = req_q.second_operand;
    s     = req_q.amount;
    fin   = req_q.flags_in;
    sgn   = req_q.signed_mode;
    right = req_q.right_or_min;
    z     = fin[FlagZ];
    n     = fin[FlagN];
    c     = fin[FlagC];
    v     = fin[FlagV];

    // byte operand for the alu group
    b = b_raw;
    if (req_q.operation <= OP_MUL && req_q.byte_operand) begin
      b = {(sgn && b_raw[7]) ? 8'hff : 8'h00, b_raw[7:0]};
    end

    sum  = {1'b0, a} + {1'b0, b};
    diff = a - b;

    ae   = sgn ? {{16{a[15]}}, a} : {16'h0000, a};
    be   = sgn ? {{16{b[15]}}, b} : {16'h0000, b};
    prod = ae * be;

    inv_s   = 5'd16 - {1'b0, s};
    rc_amt  = 5'd17 - {1'b0, s};
    dbl     = {a, a};
    dbl_l   = dbl << s;
    v17     = {c, a};
    dv      = {v17, v17};
    sh_l    = a << s;
    sh_r    = a >> s;
    sh_a    = 16'($signed(a) >>> s);
    rot_r   = 16'(dbl >> s);
    rot_l   = dbl_l[31:16];
    rc_r    = 16'(dv >> s);
    rc_l    = 16'(dv >> rc_amt);
    c_left  = a[inv_s[3:0]];
    c_right = a[s - 4'd1];

    a_less   = sgn ? ($signed(a) < $signed(b_raw)) : (a < b_raw);
    bit_mask = 16'h0001 << s;
    bit_set  = a[s];

    res   = a;
    f     = 4'b0000;
    mask  = MaskNone;
    wb    = 1'b0;
    cond  = 1'b0;
    shres = a;

    unique case (req_q.operation) inside
      OP_ADD: begin
        res      = sum[15:0];
        f[FlagZ] = (sum[15:0] == 16'h0000);
        f[FlagN] = sum[15];
        f[FlagC] = sum[16];
        f[FlagV] = (a[15] ^ sum[15]) & (b[15] ^ sum[15]);
        mask     = MaskAll;
        wb       = 1'b1;
      end
      OP_SUB, OP_CMP: begin
        f[FlagZ] = (diff == 16'h0000);
        f[FlagN] = diff[15];
        f[FlagC] = b > a;
        f[FlagV] = (a[15] ^ b[15]) & (a[15] ^ diff[15]);
        mask     = MaskAll;
        if (req_q.operation == OP_SUB) begin
          res = diff;
          wb  = 1'b1;
        end
      end
      OP_AND, OP_OR, OP_XOR, OP_PASS: begin
        case (req_q.operation)
          OP_AND:  res = a & b;
          OP_OR:   res = a | b;
          OP_XOR:  res = a ^ b;
          default: res = b;
        endcase
        f[FlagZ] = (res == 16'h0000);
        f[FlagN] = res[15];
        mask     = MaskAll;
        wb       = 1'b1;
      end
      OP_MUL: begin
        res      = prod[15:0];
        f[FlagZ] = (prod == 32'h0000_0000);
        f[FlagN] = prod[15];
        f[FlagC] = (prod & MulHighMask) != 32'h0000_0000;
        f[FlagV] = (prod >= MulPosLimit) && (prod < MulNegLimit);
        mask     = MaskAll;
        wb       = 1'b1;
      end
      OP_LSHIFT, OP_ASHIFT, OP_ROTATE: begin
        mask = MaskAll;
        wb   = 1'b1;
        if (s == 4'd0) begin
          res      = a;
          f[FlagZ] = (a == 16'h0000);
          f[FlagN] = a[15];
        end else if (right) begin
          case (req_q.operation)
            OP_LSHIFT: shres = sh_r;
            OP_ASHIFT: shres = sh_a;
            default:   shres = rot_r;
          endcase
          res      = shres;
          f[FlagZ] = (shres == 16'h0000);
          f[FlagN] = (req_q.operation == OP_ASHIFT) && shres[15];
          f[FlagC] = c_right;
        end else begin
          shres    = (req_q.operation == OP_ROTATE) ? rot_l : sh_l;
          res      = shres;
          f[FlagZ] = (shres == 16'h0000);
          f[FlagN] = shres[15];
          f[FlagC] = c_left;
        end
      end
      OP_ROTCARRY: begin
        wb = 1'b1;
        if (s == 4'd0) begin
          res  = a;
          mask = MaskZnv;
        end else begin
          res      = right ? rc_r : rc_l;
          mask     = MaskAll;
          f[FlagC] = right ? c_right : c_left;
        end
        f[FlagZ] = (res == 16'h0000);
        f[FlagN] = res[15];
      end
      OP_MINMAX: begin
        if (right) begin
          res = a_less ? a : b_raw;
        end else begin
          res = a_less ? b_raw : a;
        end
        wb = 1'b1;
      end
      OP_NEGNOT: begin
        res      = sgn ? (16'h0000 - a) : ~a;
        f[FlagZ] = (res == 16'h0000);
        f[FlagN] = res[15];
        mask     = MaskAll;
        wb       = 1'b1;
      end
      OP_BTEST, OP_BSET, OP_BCLR: begin
        mask     = MaskZ;
        f[FlagZ] = !bit_set;
        if (req_q.operation == OP_BSET && !bit_set) begin
          res = a | bit_mask;
          wb  = 1'b1;
        end
        if (req_q.operation == OP_BCLR && bit_set) begin
          res = a & ~bit_mask;
          wb  = 1'b1;
        end
      end
      OP_DEC: begin
        res  = a - 16'h0001;
        wb   = 1'b1;
        cond = (a != 16'h0001);
      end
      OP_COND: begin
        case (s)
          CC_NZ:    cond = !z;
          CC_Z:     cond = z;
          CC_NC:    cond = !c;
          CC_C:     cond = c;
          CC_NN:    cond = !n;
          CC_N:     cond = n;
          CC_NV:    cond = !v;
          CC_V:     cond = v;
          CC_NEVER: cond = 1'b0;
          CC_HI:    cond = !z && !c;
          CC_LS:    cond = z || c;
          CC_GT:    cond = !z && (n == v);
          CC_GE:    cond = (n == v);
          CC_LE:    cond = z || (n != v);
          CC_LT:    cond = (n != v);
          default:  cond = 1'b1;
        endcase
      end
      default: begin
        res = a;
      end
    endcase

    rsp_d.result         = res;
    rsp_d.write_back     = wb;
    rsp_d.flags_out      = (fin & ~mask) | (f & mask);
    rsp_d.flags_written  = mask;
    rsp_d.condition_true = cond;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign chk_keep_ok = ((rsp_d.flags_out ^ req_q.flags_in) & ~rsp_d.flags_written) == 4'b0000;
  assign chk_dest_ok = rsp_d.write_back || (rsp_d.result == req_q.first_operand);
  assign chk_cond_ok = !rsp_d.condition_true || (req_q.operation inside {OP_DEC, OP_COND});

  `SBEU_ASSERT_NEXT(a_done_follows, in_vld_q, done_o)
  `SBEU_ASSERT_NEXT(a_no_spurious_done, !in_vld_q, !done_o)
  `SBEU_ASSERT_IMP(a_flags_masked, in_vld_q, chk_keep_ok)
  `SBEU_ASSERT_IMP(a_no_wb_keeps_dest, in_vld_q, chk_dest_ok)
  `SBEU_ASSERT_IMP(a_cond_source, in_vld_q, chk_cond_ok)

endmodule

`default_nettype wire
